[sv/avms_pkg.sv]
// Shared definitions for the axisymmetric von Mises stress pipeline.
// Holds default word sizes and a width helper; depends on nothing.
package avms_pkg;

    // Default word sizes of the fixed-point data.
    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    // Larger of two widths, for sizing datapaths at elaboration.
    function automatic int f_max(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

endpackage

[sv/axisymmetric_von_mises_stress.sv]
// Von Mises equivalent stress of one axisymmetric flow point per beat.
// MB is the width of the squaring multipliers; the longest part of the pipeline is the
// restoring divider chain, then the shift-add chains of the squaring multipliers.
// Throughput is one beat per cycle; the whole pipeline holds only while a result waits.
// Synchronous active-low reset clears every valid flag; data registers are not reset.
// Uses avms_pkg, avms_mul, avms_div and avms_sqrt.
module axisymmetric_von_mises_stress #(
    parameter int DATA_WIDTH = avms_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = avms_pkg::FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [DATA_WIDTH-1:0] i_pressure,
    input  logic [DATA_WIDTH-2:0] i_viscosity,
    input  logic [DATA_WIDTH-1:0] i_radial_velocity,
    input  logic [DATA_WIDTH-1:0] i_radius,
    input  logic [DATA_WIDTH-1:0] i_dur_dr,
    input  logic [DATA_WIDTH-1:0] i_dur_dz,
    input  logic [DATA_WIDTH-1:0] i_duz_dr,
    input  logic [DATA_WIDTH-1:0] i_duz_dz,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [DATA_WIDTH-1:0] o_equivalent_stress,
    output logic                  o_radius_fault,
    output logic                  o_saturated
);
    import avms_pkg::*;

    localparam int W   = DATA_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int C_W = W + F;
    localparam int PW  = f_max(2 * W - 1, C_W);
    localparam int D_W = PW + 1;
    localparam int MB  = f_max(D_W, 2 * W);
    localparam int QW  = 2 * MB + 4;
    localparam int XW  = QW + 2 * W - 2;
    localparam int N_W = XW - 2 * F;

    typedef struct packed {
        logic           fault;
        logic           neg_a;
        logic           neg_b;
        logic           neg_v;
        logic [C_W-1:0] c_mag;
    } t_tag1;

    typedef struct packed {
        logic             fault;
        logic [2*W-3:0]   rr;
        logic [2*W-3:0]   mumu;
    } t_tag2;

    typedef struct packed {
        logic           fault;
        logic [2*W-3:0] rr;
    } t_tag3;

    typedef struct packed {
        logic fault;
        logic sat;
    } t_tag5;

    logic en;

    // The pipeline moves whenever the output register is free or being drained.
    assign en      = !o_valid || i_ready;
    assign o_ready = en;

    // Input stage: signs, magnitudes and the radius check.
    logic signed [W:0] shear_sum;
    logic              n_a_fault;

    logic           r_a_vld;
    logic           r_a_fault;
    logic           r_a_neg_a;
    logic           r_a_neg_b;
    logic           r_a_neg_v;
    logic [W-1:0]   r_a_ma;
    logic [W-1:0]   r_a_mb;
    logic [C_W-1:0] r_a_mc;
    logic [W:0]     r_a_ms;
    logic [W-2:0]   r_a_r;
    logic [W-2:0]   r_a_mu;

    assign shear_sum = (W+1)'($signed(i_dur_dz)) + (W+1)'($signed(i_duz_dr));
    assign n_a_fault = i_radius[W-1] || (i_radius == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (en) begin
            r_a_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_fault <= n_a_fault;
            r_a_neg_a <= i_dur_dr[W-1];
            r_a_neg_b <= i_duz_dz[W-1];
            r_a_neg_v <= i_radial_velocity[W-1];
            r_a_ma    <= i_dur_dr[W-1] ? (W'(0) - i_dur_dr) : i_dur_dr;
            r_a_mb    <= i_duz_dz[W-1] ? (W'(0) - i_duz_dz) : i_duz_dz;
            r_a_mc    <= C_W'(i_radial_velocity[W-1] ? (W'(0) - i_radial_velocity)
                                                     : i_radial_velocity) << F;
            r_a_ms    <= shear_sum[W] ? (W+1)'(-shear_sum) : (W+1)'(shear_sum);
            r_a_r     <= i_radius[W-2:0];
            r_a_mu    <= i_viscosity;
        end
    end

    // First multiplier bank: gradient and shear terms scaled by the radius,
    // the squared radius and the squared viscosity.
    t_tag1          tag1_in;
    t_tag1          tag1_out;
    logic           m1_vld;
    logic [2*W-2:0] m1_a;
    logic [2*W-2:0] m1_b;
    logic [2*W-1:0] m1_s;
    logic [2*W-3:0] m1_rr;
    logic [2*W-3:0] m1_mumu;

    assign tag1_in.fault = r_a_fault;
    assign tag1_in.neg_a = r_a_neg_a;
    assign tag1_in.neg_b = r_a_neg_b;
    assign tag1_in.neg_v = r_a_neg_v;
    assign tag1_in.c_mag = r_a_mc;

    avms_mul #(.A_W(W), .B_W(W - 1), .T_W($bits(t_tag1))) u_mul_a (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(r_a_vld), .i_tag(tag1_in),
        .i_a(r_a_ma), .i_b(r_a_r), .o_valid(m1_vld), .o_tag(tag1_out), .o_p(m1_a)
    );

    avms_mul #(.A_W(W), .B_W(W - 1), .T_W(1)) u_mul_b (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(r_a_vld), .i_tag(1'b0),
        .i_a(r_a_mb), .i_b(r_a_r), .o_valid(), .o_tag(), .o_p(m1_b)
    );

    avms_mul #(.A_W(W + 1), .B_W(W - 1), .T_W(1)) u_mul_s (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(r_a_vld), .i_tag(1'b0),
        .i_a(r_a_ms), .i_b(r_a_r), .o_valid(), .o_tag(), .o_p(m1_s)
    );

    avms_mul #(.A_W(W - 1), .B_W(W - 1), .T_W(1)) u_mul_rr (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(r_a_vld), .i_tag(1'b0),
        .i_a(r_a_r), .i_b(r_a_r), .o_valid(), .o_tag(), .o_p(m1_rr)
    );

    avms_mul #(.A_W(W - 1), .B_W(W - 1), .T_W(1)) u_mul_mu (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(r_a_vld), .i_tag(1'b0),
        .i_a(r_a_mu), .i_b(r_a_mu), .o_valid(), .o_tag(), .o_p(m1_mumu)
    );

    // Differences of the normal stresses, all scaled by the radius.
    logic signed [PW:0]   s_a;
    logic signed [PW:0]   s_b;
    logic signed [PW:0]   s_c;
    logic signed [PW+1:0] d1;
    logic signed [PW+1:0] d2;
    logic signed [PW+1:0] d3;

    assign s_a = tag1_out.neg_a ? -$signed({1'b0, PW'(m1_a)}) : $signed({1'b0, PW'(m1_a)});
    assign s_b = tag1_out.neg_b ? -$signed({1'b0, PW'(m1_b)}) : $signed({1'b0, PW'(m1_b)});
    assign s_c = tag1_out.neg_v ? -$signed({1'b0, PW'(tag1_out.c_mag)})
                                : $signed({1'b0, PW'(tag1_out.c_mag)});
    assign d1  = (PW+2)'(s_a) - (PW+2)'(s_b);
    assign d2  = (PW+2)'(s_b) - (PW+2)'(s_c);
    assign d3  = (PW+2)'(s_c) - (PW+2)'(s_a);

    logic           r_b_vld;
    logic [D_W-1:0] r_b_d1;
    logic [D_W-1:0] r_b_d2;
    logic [D_W-1:0] r_b_d3;
    logic [2*W-1:0] r_b_s;
    t_tag2          r_b_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (en) begin
            r_b_vld <= m1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_d1        <= d1[PW+1] ? D_W'(-d1) : d1[PW:0];
            r_b_d2        <= d2[PW+1] ? D_W'(-d2) : d2[PW:0];
            r_b_d3        <= d3[PW+1] ? D_W'(-d3) : d3[PW:0];
            r_b_s         <= m1_s;
            r_b_tag.fault <= tag1_out.fault;
            r_b_tag.rr    <= m1_rr;
            r_b_tag.mumu  <= m1_mumu;
        end
    end

    // Second multiplier bank: the four squares.
    t_tag2           tag2_out;
    logic            m2_vld;
    logic [2*MB-1:0] sq1;
    logic [2*MB-1:0] sq2;
    logic [2*MB-1:0] sq3;
    logic [2*MB-1:0] sq4;

    avms_mul #(.A_W(MB), .B_W(MB), .T_W($bits(t_tag2))) u_sq_1 (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(r_b_vld), .i_tag(r_b_tag),
        .i_a(MB'(r_b_d1)), .i_b(MB'(r_b_d1)), .o_valid(m2_vld), .o_tag(tag2_out), .o_p(sq1)
    );

    avms_mul #(.A_W(MB), .B_W(MB), .T_W(1)) u_sq_2 (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(r_b_vld), .i_tag(1'b0),
        .i_a(MB'(r_b_d2)), .i_b(MB'(r_b_d2)), .o_valid(), .o_tag(), .o_p(sq2)
    );

    avms_mul #(.A_W(MB), .B_W(MB), .T_W(1)) u_sq_3 (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(r_b_vld), .i_tag(1'b0),
        .i_a(MB'(r_b_d3)), .i_b(MB'(r_b_d3)), .o_valid(), .o_tag(), .o_p(sq3)
    );

    avms_mul #(.A_W(MB), .B_W(MB), .T_W(1)) u_sq_4 (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(r_b_vld), .i_tag(1'b0),
        .i_a(MB'(r_b_s)), .i_b(MB'(r_b_s)), .o_valid(), .o_tag(), .o_p(sq4)
    );

    // Twice the sum of squared differences plus three times the squared shear.
    logic [QW-1:0] n_c_q;
    logic          r_c_vld;
    logic [QW-1:0] r_c_q;
    t_tag3         r_c_tag;
    logic [2*W-3:0] r_c_mumu;

    assign n_c_q = ((QW'(sq1) + QW'(sq2) + QW'(sq3)) << 1) + (QW'(sq4) << 1) + QW'(sq4);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (en) begin
            r_c_vld <= m2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_q         <= n_c_q;
            r_c_tag.fault <= tag2_out.fault;
            r_c_tag.rr    <= tag2_out.rr;
            r_c_mumu      <= tag2_out.mumu;
        end
    end

    // Third multiplier: scale by the squared viscosity.
    t_tag3         tag3_out;
    logic          m3_vld;
    logic [XW-1:0] m3_x;

    avms_mul #(.A_W(QW), .B_W(2 * W - 2), .T_W($bits(t_tag3))) u_mul_x (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(r_c_vld), .i_tag(r_c_tag),
        .i_a(r_c_q), .i_b(r_c_mumu), .o_valid(m3_vld), .o_tag(tag3_out), .o_p(m3_x)
    );

    // Divide by the squared radius and the fraction scale; the quotient's root is the result.
    logic           dv_vld;
    logic           dv_fault;
    logic           dv_sat;
    logic [2*W-1:0] dv_q;

    avms_div #(.N_W(N_W), .D_W(2 * W - 2), .Q_W(2 * W), .T_W(1)) u_div (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(m3_vld), .i_tag(tag3_out.fault),
        .i_n(N_W'(m3_x >> (2 * F))), .i_d(tag3_out.rr),
        .o_valid(dv_vld), .o_tag(dv_fault), .o_sat(dv_sat), .o_q(dv_q)
    );

    t_tag5        tag5_in;
    t_tag5        tag5_out;
    logic         sq_vld;
    logic [W-1:0] sq_s;

    assign tag5_in.fault = dv_fault;
    assign tag5_in.sat   = dv_sat;

    avms_sqrt #(.S_W(W), .T_W($bits(t_tag5))) u_sqrt (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(dv_vld), .i_tag(tag5_in),
        .i_y(dv_q), .o_valid(sq_vld), .o_tag(tag5_out), .o_s(sq_s)
    );

    // Output register: a radius fault wins over saturation.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (en) begin
            o_valid <= sq_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_radius_fault <= tag5_out.fault;
            o_saturated    <= tag5_out.sat && !tag5_out.fault;
            if (tag5_out.fault) begin
                o_equivalent_stress <= '0;
            end else if (tag5_out.sat) begin
                o_equivalent_stress <= '1;
            end else begin
                o_equivalent_stress <= sq_s;
            end
        end
    end

endmodule

[sv/avms_mul.sv]
// Pipelined shift-add multiplier: one cell per multiplier bit.
// Carries a sideband tag alongside the operands; no dependencies.
module avms_mul #(
    parameter int A_W = 32,
    parameter int B_W = 32,
    parameter int T_W = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [T_W-1:0]       i_tag,
    input  logic [A_W-1:0]       i_a,
    input  logic [B_W-1:0]       i_b,
    output logic                 o_valid,
    output logic [T_W-1:0]       o_tag,
    output logic [A_W+B_W-1:0]   o_p
);
    localparam int P_W = A_W + B_W;

    logic             r_vld [B_W];
    logic [T_W-1:0]   r_tag [B_W];
    logic [A_W-1:0]   r_a   [B_W];
    logic [B_W-1:0]   r_b   [B_W];
    logic [P_W-1:0]   r_acc [B_W];

    for (genvar j = 0; j < B_W; j++) begin : g_cell
        logic           vld_in;
        logic [T_W-1:0] tag_in;
        logic [A_W-1:0] a_in;
        logic [B_W-1:0] b_in;
        logic [P_W-1:0] acc_in;
        logic [P_W-1:0] n_acc;

        // The first cell takes the operands, later cells their neighbour.
        if (j == 0) begin : g_head
            assign vld_in = i_valid;
            assign tag_in = i_tag;
            assign a_in   = i_a;
            assign b_in   = i_b;
            assign acc_in = '0;
        end else begin : g_link
            assign vld_in = r_vld[j-1];
            assign tag_in = r_tag[j-1];
            assign a_in   = r_a[j-1];
            assign b_in   = r_b[j-1];
            assign acc_in = r_acc[j-1];
        end

        // Add the shifted multiplicand when this cell's bit is set.
        assign n_acc = b_in[j] ? (acc_in + (P_W'(a_in) << j)) : acc_in;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else if (i_en) begin
                r_vld[j] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_tag[j] <= tag_in;
                r_a[j]   <= a_in;
                r_b[j]   <= b_in;
                r_acc[j] <= n_acc;
            end
        end
    end

    assign o_valid = r_vld[B_W-1];
    assign o_tag   = r_tag[B_W-1];
    assign o_p     = r_acc[B_W-1];

endmodule

[sv/avms_div.sv]
// Restoring divider as a chain of cells, one quotient bit per cell.
// A head stage flags quotients too large for the result; uses avms_pkg.
module avms_div #(
    parameter int N_W = 64,
    parameter int D_W = 32,
    parameter int Q_W = 32,
    parameter int T_W = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [T_W-1:0]   i_tag,
    input  logic [N_W-1:0]   i_n,
    input  logic [D_W-1:0]   i_d,
    output logic             o_valid,
    output logic [T_W-1:0]   o_tag,
    output logic             o_sat,
    output logic [Q_W-1:0]   o_q
);
    import avms_pkg::*;

    localparam int H_W = N_W - Q_W;
    localparam int C_W = f_max(H_W, D_W);

    logic [H_W-1:0] hi;
    logic           n_h_sat;

    logic           r_h_vld;
    logic [T_W-1:0] r_h_tag;
    logic           r_h_sat;
    logic [D_W-1:0] r_h_rem;
    logic [Q_W-1:0] r_h_low;
    logic [D_W-1:0] r_h_d;

    logic             r_vld [Q_W];
    logic [T_W-1:0]   r_tag [Q_W];
    logic             r_sat [Q_W];
    logic [D_W-1:0]   r_rem [Q_W];
    logic [Q_W-1:0]   r_low [Q_W];
    logic [D_W-1:0]   r_d   [Q_W];
    logic [Q_W-1:0]   r_q   [Q_W];

    // Head: the quotient overflows when the upper dividend part reaches the divisor.
    assign hi      = i_n[N_W-1:Q_W];
    assign n_h_sat = C_W'(hi) >= C_W'(i_d);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_vld <= 1'b0;
        end else if (i_en) begin
            r_h_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_h_tag <= i_tag;
            r_h_sat <= n_h_sat;
            r_h_rem <= D_W'(hi);
            r_h_low <= i_n[Q_W-1:0];
            r_h_d   <= i_d;
        end
    end

    for (genvar j = 0; j < Q_W; j++) begin : g_cell
        logic           vld_in;
        logic [T_W-1:0] tag_in;
        logic           sat_in;
        logic [D_W-1:0] rem_in;
        logic [Q_W-1:0] low_in;
        logic [D_W-1:0] d_in;
        logic [Q_W-1:0] q_in;
        logic [D_W:0]   trial;
        logic           ge;
        logic [D_W:0]   diff;
        logic [D_W-1:0] n_rem;

        if (j == 0) begin : g_head
            assign vld_in = r_h_vld;
            assign tag_in = r_h_tag;
            assign sat_in = r_h_sat;
            assign rem_in = r_h_rem;
            assign low_in = r_h_low;
            assign d_in   = r_h_d;
            assign q_in   = '0;
        end else begin : g_link
            assign vld_in = r_vld[j-1];
            assign tag_in = r_tag[j-1];
            assign sat_in = r_sat[j-1];
            assign rem_in = r_rem[j-1];
            assign low_in = r_low[j-1];
            assign d_in   = r_d[j-1];
            assign q_in   = r_q[j-1];
        end

        // Bring down the next dividend bit and subtract where it fits.
        assign trial = {rem_in, low_in[Q_W-1]};
        assign ge    = trial >= (D_W+1)'(d_in);
        assign diff  = trial - (D_W+1)'(d_in);
        assign n_rem = ge ? diff[D_W-1:0] : trial[D_W-1:0];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else if (i_en) begin
                r_vld[j] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_tag[j] <= tag_in;
                r_sat[j] <= sat_in;
                r_rem[j] <= n_rem;
                r_low[j] <= low_in << 1;
                r_d[j]   <= d_in;
                r_q[j]   <= {q_in[Q_W-2:0], ge};
            end
        end
    end

    assign o_valid = r_vld[Q_W-1];
    assign o_tag   = r_tag[Q_W-1];
    assign o_sat   = r_sat[Q_W-1];
    assign o_q     = r_q[Q_W-1];

endmodule

[sv/avms_sqrt.sv]
// Integer square root as a chain of cells, one root bit per cell.
// Each cell keeps the running remainder and partial root; no dependencies.
module avms_sqrt #(
    parameter int S_W = 32,
    parameter int T_W = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [T_W-1:0]   i_tag,
    input  logic [2*S_W-1:0] i_y,
    output logic             o_valid,
    output logic [T_W-1:0]   o_tag,
    output logic [S_W-1:0]   o_s
);
    localparam int Y_W = 2 * S_W;

    logic             r_vld [S_W];
    logic [T_W-1:0]   r_tag [S_W];
    logic [Y_W-1:0]   r_rem [S_W];
    logic [S_W-1:0]   r_s   [S_W];

    for (genvar j = 0; j < S_W; j++) begin : g_cell
        localparam int K = S_W - 1 - j;

        logic           vld_in;
        logic [T_W-1:0] tag_in;
        logic [Y_W-1:0] rem_in;
        logic [S_W-1:0] s_in;
        logic [Y_W:0]   trial;
        logic           ge;

        if (j == 0) begin : g_head
            assign vld_in = i_valid;
            assign tag_in = i_tag;
            assign rem_in = i_y;
            assign s_in   = '0;
        end else begin : g_link
            assign vld_in = r_vld[j-1];
            assign tag_in = r_tag[j-1];
            assign rem_in = r_rem[j-1];
            assign s_in   = r_s[j-1];
        end

        // Setting bit K grows the square by s*2^(K+1) + 2^(2K).
        assign trial = ((Y_W+1)'(s_in) << (K + 1)) + ((Y_W+1)'(1) << (2 * K));
        assign ge    = (Y_W+1)'(rem_in) >= trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else if (i_en) begin
                r_vld[j] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_tag[j] <= tag_in;
                r_rem[j] <= ge ? (rem_in - trial[Y_W-1:0]) : rem_in;
                r_s[j]   <= ge ? (s_in | (S_W'(1) << K)) : s_in;
            end
        end
    end

    assign o_valid = r_vld[S_W-1];
    assign o_tag   = r_tag[S_W-1];
    assign o_s     = r_s[S_W-1];

endmodule
